/* hw/rtl/pcbp_pkg.sv */
// ----------------------------------------------------------------------------
// pcbp_pkg: shared types and constants for the prefix code bit packer.
// Holds the transaction payload types, the operation codes and the code
// table entry layout.
// ----------------------------------------------------------------------------
package pcbp_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam int MAX_CODE_BITS = 32;

   localparam int SYM_W   = 8;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int PEND_W  = 7;
   localparam int PCNT_W  = 3;
   localparam int BV_W    = 4;

   // Stored code length never exceeds this.
   localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

   localparam int TBL_IDX_W = $clog2(ALPHABET_SIZE);
   localparam int ACC_W     = PEND_W + CODE_W;
   localparam int MAX_BYTES = 4;
   localparam int NB_W      = 3;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SYM_W-1:0]    symbol;
      logic [CODE_W-1:0]   code_bits;
      logic [LEN_W-1:0]    code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [BV_W-1:0]     bits_valid;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]    len;
      logic [CODE_W-1:0]   code;
   } tbl_entry_type;

endpackage

/* hw/rtl/prefix_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// prefix_code_bit_packer: prefix code encoder and bit packer.
// Loads a per-symbol code table, encodes bytes into packed output bytes and
// flushes the partial byte at the end of a stream.
// ----------------------------------------------------------------------------
// Usage:
// Transactions enter on the req_ channel: a load writes one code table entry,
// an encode appends the code of one symbol to the bit accumulator and a flush
// drains the partial byte. Result bytes leave on the rsp_ channel, earliest
// bit in bit 0, with last marking the final byte caused by one transaction.
// The code table sits in a single-port memory addressed at acceptance; its
// read data is registered and used when the transaction is packed, and its
// bytes go to an output register that shifts out one byte per cycle while
// the receiver accepts. The first result byte passes the read data register
// and then the output register. An item of n bytes (one to four) holds the
// output register until all are taken; loads never wait for it. The next
// transaction is accepted while bytes are still being delivered. Reset
// clears the table valid flags at once, so every entry reads as absent, and
// clears the pending bits. When the receiver stalls, the output register
// holds its byte; an item with bytes to emit waits and req_ready drops.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcbp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcbp_pkg::rsp_type rsp_payload
);

   localparam int LEN_W  = pcbp_pkg::LEN_W;
   localparam int CODE_W = pcbp_pkg::CODE_W;
   localparam int ACC_W  = pcbp_pkg::ACC_W;
   localparam int PEND_W = pcbp_pkg::PEND_W;
   localparam int PCNT_W = pcbp_pkg::PCNT_W;
   localparam int NB_W   = pcbp_pkg::NB_W;
   localparam int IDX_W  = pcbp_pkg::TBL_IDX_W;

   // Code table memory and its valid flags.
   pcbp_pkg::tbl_entry_type tbl_mem [pcbp_pkg::ALPHABET_SIZE];
   logic [pcbp_pkg::ALPHABET_SIZE-1:0] tbl_vld_ff;

   logic                      req_fire;
   logic                      sym_in_range;
   logic [IDX_W-1:0]          tbl_idx;
   logic [LEN_W-1:0]          load_len;
   logic [CODE_W:0]           load_mask_wide;
   pcbp_pkg::tbl_entry_type   load_entry;

   // Packing stage.
   logic                      s1_valid_ff;
   pcbp_pkg::op_type          s1_op_ff;
   logic                      s1_hit_ff;
   pcbp_pkg::tbl_entry_type   rd_data_ff;

   logic [PEND_W-1:0]         pend_bits_ff;
   logic [PCNT_W-1:0]         pend_cnt_ff;
   logic [PEND_W-1:0]         pend_bits_in;
   logic [PCNT_W-1:0]         pend_cnt_in;

   logic [LEN_W-1:0]          enc_len;
   logic [ACC_W-1:0]          enc_acc;
   logic [ACC_W-1:0]          enc_rest;
   logic [LEN_W-1:0]          enc_total;
   logic [NB_W-1:0]           enc_nbytes;
   logic [PEND_W:0]           enc_pmask;
   logic                      needs_emit;
   logic                      emit_free;
   logic                      s1_done;

   // Output register.
   logic [CODE_W-1:0]         emit_data_ff;
   logic [NB_W-1:0]           emit_cnt_ff;
   logic [pcbp_pkg::BV_W-1:0] emit_bv_ff;
   logic [CODE_W-1:0]         emit_data_in;
   logic [NB_W-1:0]           emit_cnt_in;
   logic [pcbp_pkg::BV_W-1:0] emit_bv_in;
   logic                      rsp_fire;

   assign req_fire     = req_valid && req_ready;
   assign rsp_fire     = rsp_valid && rsp_ready;
   assign sym_in_range = ({1'b0, req_payload.symbol} <
                          (pcbp_pkg::SYM_W + 1)'(pcbp_pkg::ALPHABET_SIZE));
   assign tbl_idx      = req_payload.symbol[IDX_W-1:0];

   always_comb begin
      if (req_payload.code_length > LEN_W'(pcbp_pkg::LEN_LIMIT)) begin
         load_len = LEN_W'(pcbp_pkg::LEN_LIMIT);
      end else begin
         load_len = req_payload.code_length;
      end
      load_mask_wide  = ((CODE_W + 1)'(1) << load_len) - (CODE_W + 1)'(1);
      load_entry.len  = load_len;
      load_entry.code = req_payload.code_bits & load_mask_wide[CODE_W-1:0];
   end

   // Table write on load, registered read on every other transaction.
   always_ff @(posedge clock) begin
      if (req_fire && sym_in_range) begin
         if (req_payload.op == pcbp_pkg::OP_LOAD) begin
            tbl_mem[tbl_idx] <= load_entry;
         end else begin
            rd_data_ff <= tbl_mem[tbl_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
      end else if (req_fire && sym_in_range && req_payload.op == pcbp_pkg::OP_LOAD) begin
         tbl_vld_ff[tbl_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= req_payload.op;
         s1_hit_ff <= sym_in_range && tbl_vld_ff[tbl_idx];
      end
   end

   // Pack the looked-up code behind the pending bits.
   always_comb begin
      enc_len    = s1_hit_ff ? rd_data_ff.len : '0;
      enc_acc    = ACC_W'(pend_bits_ff) | (ACC_W'(rd_data_ff.code) << pend_cnt_ff);
      enc_total  = LEN_W'(pend_cnt_ff) + enc_len;
      enc_nbytes = enc_total[LEN_W-1:3];
      enc_rest   = enc_acc >> {enc_nbytes, 3'b000};
      enc_pmask  = ((PEND_W + 1)'(1) << enc_total[2:0]) - (PEND_W + 1)'(1);

      needs_emit = (s1_op_ff == pcbp_pkg::OP_FLUSH) ||
                   (s1_op_ff == pcbp_pkg::OP_ENCODE && enc_nbytes != '0);
      emit_free  = (emit_cnt_ff == '0) || (emit_cnt_ff == NB_W'(1) && rsp_ready);
      s1_done    = s1_valid_ff && (!needs_emit || emit_free);
      req_ready  = !s1_valid_ff || s1_done;
   end

   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      emit_data_in = emit_data_ff;
      emit_cnt_in  = emit_cnt_ff;
      emit_bv_in   = emit_bv_ff;
      if (rsp_fire) begin
         emit_data_in = emit_data_ff >> pcbp_pkg::BYTE_W;
         emit_cnt_in  = emit_cnt_ff - NB_W'(1);
      end
      if (s1_done) begin
         case (s1_op_ff)
            pcbp_pkg::OP_ENCODE: begin
               pend_bits_in = enc_rest[PEND_W-1:0] & enc_pmask[PEND_W-1:0];
               pend_cnt_in  = enc_total[2:0];
               if (enc_nbytes != '0) begin
                  emit_data_in = enc_acc[CODE_W-1:0];
                  emit_cnt_in  = enc_nbytes;
                  emit_bv_in   = pcbp_pkg::BV_W'(pcbp_pkg::BYTE_W);
               end
            end
            pcbp_pkg::OP_FLUSH: begin
               pend_bits_in = '0;
               pend_cnt_in  = '0;
               emit_data_in = CODE_W'(pend_bits_ff);
               emit_cnt_in  = NB_W'(1);
               emit_bv_in   = pcbp_pkg::BV_W'(pend_cnt_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         emit_cnt_ff  <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_data_ff <= emit_data_in;
      emit_bv_ff   <= emit_bv_in;
   end

   assign rsp_valid              = (emit_cnt_ff != '0);
   assign rsp_payload.out_byte   = emit_data_ff[pcbp_pkg::BYTE_W-1:0];
   assign rsp_payload.bits_valid = emit_bv_ff;
   assign rsp_payload.last       = (emit_cnt_ff == NB_W'(1));

   a_emit_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= NB_W'(pcbp_pkg::MAX_BYTES))
      else $error("output byte count exceeds four");

   a_full_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> rsp_payload.bits_valid == 4'd8)
      else $error("non-final byte is not full");

   a_pend_clean: assert property (@(posedge clock) disable iff (reset)
      (pend_bits_ff >> pend_cnt_ff) == '0)
      else $error("pending bits above pending count are set");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      s1_done && s1_op_ff == pcbp_pkg::OP_FLUSH |=> pend_cnt_ff == '0 && rsp_valid)
      else $error("flush did not clear pending state");

   a_no_accept_when_busy: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && needs_emit && !emit_free |-> !req_ready)
      else $error("transaction accepted while packing stage stalled");

endmodule
